// ----- rtl/core/shtm_pkg.sv -----
// Shared types, constants and helpers for the transfer matrix accumulator.
package shtm_pkg;

	localparam int MAX_BANDS   = 4;
	localparam int MAX_COEFFS  = MAX_BANDS * MAX_BANDS;
	localparam int IDX_W       = 4;
	localparam int N2_W        = $clog2(MAX_COEFFS + 1);
	localparam int FRAC_BITS   = 14;
	localparam int WEIGHT_FRAC = 20;
	localparam int ACC_W       = 48;
	localparam int BANDS_W     = 3;
	localparam int WEIGHT_W    = 24;
	localparam int CFG_W       = 24;
	localparam int VEC_W       = 16;
	localparam int GC_W        = 32;
	localparam int ENTRY_W     = 32;

	localparam logic [BANDS_W-1:0]  BANDS_RESET  = 3'd4;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 24'd12868;

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_COEFF  = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_SH_BANDS      = 1'b0,
		REG_SAMPLE_WEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		cmd_t                    command;
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
		logic [IDX_W-1:0]        coeff_index;
		logic signed [VEC_W-1:0] coeff_value;
		logic [IDX_W-1:0]        row_index;
	} item_t;

	typedef struct packed {
		logic signed [ENTRY_W-1:0] entry_value;
		logic [IDX_W-1:0]          entry_row;
		logic [IDX_W-1:0]          entry_column;
		logic                      last_of_row;
	} result_t;

	// Row token that travels down the cell chain during an update
	typedef struct packed {
		logic                   vld;
		logic [IDX_W-1:0]       row;
		logic [N2_W-1:0]        n2;
		logic signed [GC_W-1:0] gc;
	} tok_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SUMSQ,
		N_SQRT,
		N_LOAD,
		N_DIV,
		N_DONE
	} norm_state_t;

	typedef enum logic [2:0] {
		C_IDLE,
		C_NORM,
		C_DOT,
		C_UPD,
		C_DRAIN,
		C_RD_REQ,
		C_RD_LOAD,
		C_RD_OUT
	} ctl_state_t;

	// Coefficient count from the band register, band count clamped to 1..MAX_BANDS
	function automatic logic [N2_W-1:0] coeff_count(input logic [BANDS_W-1:0] bands);
		logic [BANDS_W-1:0] b;
		if (bands == '0) begin
			b = BANDS_W'(1);
		end else if (bands > BANDS_W'(MAX_BANDS)) begin
			b = BANDS_W'(MAX_BANDS);
		end else begin
			b = bands;
		end
		return N2_W'(b) * N2_W'(b);
	endfunction

endpackage

// ----- rtl/core/shtm_norm.sv -----
// Sequential vector normalizer: sum of squares, bit-serial square root, restoring divide.
module shtm_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [shtm_pkg::VEC_W-1:0]    vec_x,
	input  logic signed [shtm_pkg::VEC_W-1:0]    vec_y,
	input  logic signed [shtm_pkg::VEC_W-1:0]    vec_z,
	output logic                                 done,
	output logic [2:0][shtm_pkg::VEC_W-1:0]      unit
);

	localparam int SQRT_STEPS = 32;
	localparam int QUOT_BITS  = 15;
	localparam int ROOT_W     = 63;
	localparam int REM_W      = 45;
	localparam int MAG_W      = 32;
	localparam int CNT_W      = $clog2(SQRT_STEPS);
	localparam int NUM_SHIFT  = shtm_pkg::FRAC_BITS + 15;

	shtm_pkg::norm_state_t state_q, state_d;

	logic [CNT_W-1:0]                 cnt_q;
	logic [1:0]                       comp_q;
	logic [2:0][shtm_pkg::VEC_W-1:0]  vec_q;
	logic [31:0]                      s_q;
	logic [ROOT_W-1:0]                v_q, res_q, bit_q;
	logic [REM_W-1:0]                 rem_q, dsh_q;
	logic [QUOT_BITS-1:0]             quot_q;
	logic [2:0][shtm_pkg::VEC_W-1:0]  unit_q;

	logic signed [31:0]               sel_s;
	logic [31:0]                      sq;
	logic [31:0]                      s_next;
	logic [ROOT_W-1:0]                trial;
	logic [MAG_W-1:0]                 mag;
	logic signed [shtm_pkg::VEC_W-1:0] comp_v;
	logic [shtm_pkg::VEC_W-1:0]       comp_a;
	logic                             qbit;
	logic [QUOT_BITS-1:0]             quot_n;
	logic [shtm_pkg::VEC_W-1:0]       unit_n;

	// Square the selected component and form the divide operands
	always_comb begin
		sel_s  = 32'($signed(vec_q[cnt_q[1:0]]));
		sq     = 32'(sel_s * sel_s);
		s_next = s_q + sq;
		trial  = res_q + bit_q;
		mag    = res_q[MAG_W-1:0];
		comp_v = $signed(vec_q[comp_q]);
		comp_a = comp_v[shtm_pkg::VEC_W-1] ? shtm_pkg::VEC_W'(-comp_v) : comp_v;
		qbit   = rem_q >= dsh_q;
		quot_n = {quot_q[QUOT_BITS-2:0], qbit};
		unit_n = comp_v[shtm_pkg::VEC_W-1] ? shtm_pkg::VEC_W'(-quot_n) :
			shtm_pkg::VEC_W'(quot_n);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shtm_pkg::N_IDLE: begin
				if (start) begin
					state_d = shtm_pkg::N_SUMSQ;
				end
			end
			shtm_pkg::N_SUMSQ: begin
				if (cnt_q == CNT_W'(2)) begin
					state_d = shtm_pkg::N_SQRT;
				end
			end
			shtm_pkg::N_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = shtm_pkg::N_LOAD;
				end
			end
			shtm_pkg::N_LOAD: begin
				state_d = shtm_pkg::N_DIV;
			end
			shtm_pkg::N_DIV: begin
				if (cnt_q == CNT_W'(QUOT_BITS - 1)) begin
					state_d = (comp_q == 2'd2) ? shtm_pkg::N_DONE : shtm_pkg::N_LOAD;
				end
			end
			shtm_pkg::N_DONE: begin
				state_d = shtm_pkg::N_IDLE;
			end
			default: begin
				state_d = shtm_pkg::N_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		done = state_q == shtm_pkg::N_DONE;
		unit = unit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shtm_pkg::N_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Datapath: one step of the active phase per cycle
	always_ff @(posedge clk) begin
		unique case (state_q)
			shtm_pkg::N_IDLE: begin
				if (start) begin
					vec_q  <= {vec_z, vec_y, vec_x};
					s_q    <= '0;
					cnt_q  <= '0;
					comp_q <= '0;
				end
			end
			shtm_pkg::N_SUMSQ: begin
				s_q   <= s_next;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(2)) begin
					v_q   <= ROOT_W'(s_next) << 30;
					res_q <= '0;
					bit_q <= ROOT_W'(1) << 62;
					cnt_q <= '0;
				end
			end
			shtm_pkg::N_SQRT: begin
				if (v_q >= trial) begin
					v_q   <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			shtm_pkg::N_LOAD: begin
				rem_q  <= (REM_W'(comp_a) << NUM_SHIFT) + REM_W'(mag >> 1);
				dsh_q  <= REM_W'(mag) << (QUOT_BITS - 1);
				quot_q <= '0;
				cnt_q  <= '0;
			end
			shtm_pkg::N_DIV: begin
				if (qbit) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q  <= dsh_q >> 1;
				quot_q <= quot_n;
				cnt_q  <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUOT_BITS - 1)) begin
					unit_q[comp_q] <= (s_q == '0) ? '0 : unit_n;
					comp_q         <= comp_q + 2'd1;
				end
			end
			shtm_pkg::N_DONE: begin
				cnt_q <= '0;
			end
			default: begin
				cnt_q <= '0;
			end
		endcase
	end

endmodule

// ----- rtl/core/shtm_cell.sv -----
// One matrix column: multiply-accumulate on passing row tokens, row readout shift stage.
module shtm_cell (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [shtm_pkg::IDX_W-1:0]           col,
	input  logic                                 clr,
	input  logic                                 cwr,
	input  logic [shtm_pkg::IDX_W-1:0]           cidx,
	input  logic signed [shtm_pkg::VEC_W-1:0]    cval,
	input  shtm_pkg::tok_t                       tok_in,
	output shtm_pkg::tok_t                       tok_out,
	input  logic                                 rd_req,
	input  logic [shtm_pkg::IDX_W-1:0]           rd_row,
	input  logic                                 load,
	input  logic                                 shift,
	input  logic signed [shtm_pkg::ACC_W-1:0]    sh_in,
	output logic signed [shtm_pkg::ACC_W-1:0]    sh_out
);

	localparam int ACC_W = shtm_pkg::ACC_W;
	localparam int ROWS  = shtm_pkg::MAX_COEFFS;

	logic signed [ACC_W-1:0]          mem [ROWS];
	logic [ROWS-1:0]                  vbit_q;
	shtm_pkg::tok_t                   tok_q;
	logic signed [shtm_pkg::VEC_W-1:0] coef_q;
	logic signed [ACC_W-1:0]          mrd_q;
	logic                             mv_q;
	logic signed [ACC_W-1:0]          p_s1;
	logic [shtm_pkg::IDX_W-1:0]       row_s1;
	logic                             upd_s1;
	logic signed [ACC_W-1:0]          sh_q;

	logic                             act;
	logic [shtm_pkg::IDX_W-1:0]       addr;
	logic signed [ACC_W-1:0]          q;
	logic signed [ACC_W-1:0]          base;
	logic signed [ACC_W:0]            sum;
	logic signed [ACC_W-1:0]          sum_sat;

	localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}});
	localparam logic signed [ACC_W:0] ACC_MIN = -ACC_MAX - (ACC_W+1)'(1);

	// Decode token, round the product and saturate the new entry
	always_comb begin
		act   = tok_in.vld && ({1'b0, col} < tok_in.n2);
		addr  = rd_req ? rd_row : tok_in.row;
		q     = (p_s1 + ACC_W'(1 << (shtm_pkg::FRAC_BITS - 1))) >>> shtm_pkg::FRAC_BITS;
		base  = mv_q ? mrd_q : '0;
		sum   = (ACC_W+1)'(base) + (ACC_W+1)'(q);
		if (sum > ACC_MAX) begin
			sum_sat = ACC_MAX[ACC_W-1:0];
		end else if (sum < ACC_MIN) begin
			sum_sat = ACC_MIN[ACC_W-1:0];
		end else begin
			sum_sat = sum[ACC_W-1:0];
		end
		tok_out = tok_q;
		sh_out  = sh_q;
	end

	// Control: pass the token on, track written rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			upd_s1 <= 1'b0;
			vbit_q <= '0;
		end else begin
			tok_q  <= tok_in;
			upd_s1 <= act;
			if (clr) begin
				vbit_q <= '0;
			end else if (upd_s1) begin
				vbit_q[row_s1] <= 1'b1;
			end
		end
	end

	// Column memory, multiply stage and readout shift stage
	always_ff @(posedge clk) begin
		mrd_q  <= mem[addr];
		mv_q   <= vbit_q[addr];
		p_s1   <= ACC_W'(tok_in.gc) * ACC_W'(coef_q);
		row_s1 <= tok_in.row;
		if (upd_s1) begin
			mem[row_s1] <= sum_sat;
		end
		if (cwr && (cidx == col)) begin
			coef_q <= cval;
		end
		if (load) begin
			sh_q <= mv_q ? mrd_q : '0;
		end else if (shift) begin
			sh_q <= sh_in;
		end
	end

endmodule

// ----- rtl/core/sh_transfer_matrix_accumulate.sv -----
// Top level: command sequencer, cosine term, chain of column cells and readout scaler.
//
// Builds one vertex's glossy transfer matrix (unshadowed). A start or sample item
// runs the normalizer (3 squaring steps, 32 square root steps, three divides and
// a done state); a sample item then computes the cosine dot product. The last
// coefficient item of a sample sends one row token per cycle down a chain of 16
// column cells, n2 tokens in all, n2 = sh_bands squared, then waits for them to
// drain. A read item loads the row into the chain through a request and a load
// state, then shifts one entry per cycle through a two-stage scaler into the
// result register; results keep flowing as long as result_stall is low.
// item_stall is high while the sequencer is busy; for a read it drops once the
// last entry has entered the scaler.
module sh_transfer_matrix_accumulate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  shtm_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output shtm_pkg::result_t                   result,
	input  logic                                cfg_wr_en,
	input  shtm_pkg::reg_idx_t                  cfg_index,
	input  logic [shtm_pkg::CFG_W-1:0]          cfg_wr_data
);

	localparam int NC      = shtm_pkg::MAX_COEFFS;
	localparam int IDX_W   = shtm_pkg::IDX_W;
	localparam int N2_W    = shtm_pkg::N2_W;
	localparam int ACC_W   = shtm_pkg::ACC_W;
	localparam int VEC_W   = shtm_pkg::VEC_W;
	localparam int HALF_W  = ACC_W / 2;
	localparam int PP_W    = HALF_W + shtm_pkg::WEIGHT_W;
	localparam int TOT_W   = ACC_W + shtm_pkg::WEIGHT_W;
	localparam int Q_W     = TOT_W - shtm_pkg::WEIGHT_FRAC;
	localparam int DOT_W   = 34;
	localparam int G_W     = 15;

	shtm_pkg::ctl_state_t state_q, state_d;

	logic [shtm_pkg::BANDS_W-1:0]   bands_q;
	logic [shtm_pkg::WEIGHT_W-1:0]  weight_q;
	logic [N2_W-1:0]                n2;

	shtm_pkg::cmd_t                 cmd_q;
	logic [2:0][VEC_W-1:0]          normal_q;
	logic [G_W-1:0]                 cos_q;
	logic signed [DOT_W-1:0]        dot_q;
	logic [1:0]                     k_q;
	logic signed [VEC_W-1:0]        coeff_q [NC];
	logic [IDX_W-1:0]               row_q;
	logic [N2_W-1:0]                run_n2_q;
	logic [IDX_W-1:0]               col_q;
	shtm_pkg::tok_t                 tok_s1;

	logic                           neg_s1;
	logic [PP_W-1:0]                ph_s1, pl_s1;
	logic [IDX_W-1:0]               col_s1;
	logic [IDX_W-1:0]               row_s1;
	logic                           last_s1;
	logic                           vld_s1;
	logic                           result_valid_q;
	shtm_pkg::result_t              result_q;

	logic                           accept;
	logic                           en;
	logic                           issue;
	logic                           rd_req;
	logic                           load;
	logic                           norm_start;
	logic                           clr;
	logic                           cwr;
	logic                           idx_ok;
	logic                           row_ok;
	logic                           norm_done;
	logic [2:0][VEC_W-1:0]          norm_unit;
	logic signed [DOT_W-1:0]        dot_n;
	logic signed [31:0]             prod;
	logic [DOT_W-1:0]               g_raw;
	logic [G_W-1:0]                 g_n;
	logic [ACC_W-1:0]               abs_v;
	logic [TOT_W-1:0]               total;
	logic [Q_W-1:0]                 qv;
	logic signed [shtm_pkg::ENTRY_W-1:0] entry_n;

	shtm_pkg::tok_t                 tok_link [NC+1];
	logic signed [ACC_W-1:0]        sh_link  [NC+1];

	assign n2 = shtm_pkg::coeff_count(bands_q);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q  <= shtm_pkg::BANDS_RESET;
			weight_q <= shtm_pkg::WEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				shtm_pkg::REG_SH_BANDS: begin
					bands_q <= cfg_wr_data[shtm_pkg::BANDS_W-1:0];
				end
				shtm_pkg::REG_SAMPLE_WEIGHT: begin
					weight_q <= cfg_wr_data[shtm_pkg::WEIGHT_W-1:0];
				end
				default: begin
					bands_q <= bands_q;
				end
			endcase
		end
	end

	// Decode the incoming item and the dot product step
	always_comb begin
		idx_ok = {1'b0, item.coeff_index} < n2;
		row_ok = {1'b0, item.row_index} < n2;
		prod   = 32'($signed(normal_q[k_q])) * 32'($signed(norm_unit[k_q]));
		dot_n  = dot_q + DOT_W'(prod);
		g_raw  = DOT_W'(dot_n + DOT_W'(1 << (shtm_pkg::FRAC_BITS - 1))) >>
			shtm_pkg::FRAC_BITS;
		if (dot_n <= 0) begin
			g_n = '0;
		end else if (g_raw > DOT_W'({G_W{1'b1}})) begin
			g_n = {G_W{1'b1}};
		end else begin
			g_n = g_raw[G_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			shtm_pkg::C_IDLE: begin
				if (accept) begin
					unique case (item.command)
						shtm_pkg::CMD_START, shtm_pkg::CMD_SAMPLE: begin
							state_d = shtm_pkg::C_NORM;
						end
						shtm_pkg::CMD_COEFF: begin
							if (idx_ok && ({1'b0, item.coeff_index} == n2 - N2_W'(1))) begin
								state_d = shtm_pkg::C_UPD;
							end
						end
						shtm_pkg::CMD_READ: begin
							if (row_ok) begin
								state_d = shtm_pkg::C_RD_REQ;
							end
						end
						default: begin
							state_d = shtm_pkg::C_IDLE;
						end
					endcase
				end
			end
			shtm_pkg::C_NORM: begin
				if (norm_done) begin
					state_d = (cmd_q == shtm_pkg::CMD_SAMPLE) ? shtm_pkg::C_DOT :
						shtm_pkg::C_IDLE;
				end
			end
			shtm_pkg::C_DOT: begin
				if (k_q == 2'd2) begin
					state_d = shtm_pkg::C_IDLE;
				end
			end
			shtm_pkg::C_UPD: begin
				if ({1'b0, row_q} == run_n2_q - N2_W'(1)) begin
					state_d = shtm_pkg::C_DRAIN;
				end
			end
			shtm_pkg::C_DRAIN: begin
				if (tok_link[NC].vld &&
					({1'b0, tok_link[NC].row} == run_n2_q - N2_W'(1))) begin
					state_d = shtm_pkg::C_IDLE;
				end
			end
			shtm_pkg::C_RD_REQ: begin
				state_d = shtm_pkg::C_RD_LOAD;
			end
			shtm_pkg::C_RD_LOAD: begin
				state_d = shtm_pkg::C_RD_OUT;
			end
			shtm_pkg::C_RD_OUT: begin
				if (issue && ({1'b0, col_q} == run_n2_q - N2_W'(1))) begin
					state_d = shtm_pkg::C_IDLE;
				end
			end
			default: begin
				state_d = shtm_pkg::C_IDLE;
			end
		endcase
	end

	// Control outputs
	always_comb begin
		item_stall = state_q != shtm_pkg::C_IDLE;
		accept     = item_valid && !item_stall;
		en         = !result_valid_q || !result_stall;
		issue      = (state_q == shtm_pkg::C_RD_OUT) && en;
		rd_req     = state_q == shtm_pkg::C_RD_REQ;
		load       = state_q == shtm_pkg::C_RD_LOAD;
		norm_start = accept && ((item.command == shtm_pkg::CMD_START) ||
			(item.command == shtm_pkg::CMD_SAMPLE));
		clr        = accept && (item.command == shtm_pkg::CMD_START);
		cwr        = accept && (item.command == shtm_pkg::CMD_COEFF) && idx_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shtm_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Vertex state: unit normal and cosine term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= '0;
			cos_q    <= '0;
		end else if ((state_q == shtm_pkg::C_NORM) && norm_done &&
			(cmd_q == shtm_pkg::CMD_START)) begin
			normal_q <= norm_unit;
			cos_q    <= '0;
		end else if ((state_q == shtm_pkg::C_DOT) && (k_q == 2'd2)) begin
			cos_q <= g_n;
		end
	end

	// Sequencer datapath: command latch, dot product, row and column counters
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.command;
			run_n2_q <= n2;
			row_q    <= (item.command == shtm_pkg::CMD_READ) ? item.row_index : '0;
			col_q    <= '0;
			k_q      <= '0;
			dot_q    <= '0;
		end
		if (cwr) begin
			coeff_q[item.coeff_index] <= item.coeff_value;
		end
		if (state_q == shtm_pkg::C_DOT) begin
			dot_q <= dot_n;
			k_q   <= k_q + 2'd1;
		end
		if (state_q == shtm_pkg::C_UPD) begin
			row_q <= row_q + IDX_W'(1);
		end
		if (issue) begin
			col_q <= col_q + IDX_W'(1);
		end
	end

	// Row token issue: G times the row coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
		end else begin
			tok_s1.vld <= state_q == shtm_pkg::C_UPD;
			tok_s1.row <= row_q;
			tok_s1.n2  <= run_n2_q;
			tok_s1.gc  <= 32'($signed({1'b0, cos_q})) * 32'(coeff_q[row_q]);
		end
	end

	shtm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vec_x  (item.vec_x),
		.vec_y  (item.vec_y),
		.vec_z  (item.vec_z),
		.done   (norm_done),
		.unit   (norm_unit)
	);

	// Chain of column cells
	assign tok_link[0]  = tok_s1;
	assign sh_link[NC]  = '0;

	for (genvar j = 0; j < NC; j++) begin : g_cell
		shtm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.col     (IDX_W'(j)),
			.clr     (clr),
			.cwr     (cwr),
			.cidx    (item.coeff_index),
			.cval    (item.coeff_value),
			.tok_in  (tok_link[j]),
			.tok_out (tok_link[j+1]),
			.rd_req  (rd_req),
			.rd_row  (row_q),
			.load    (load),
			.shift   (issue),
			.sh_in   (sh_link[j+1]),
			.sh_out  (sh_link[j])
		);
	end

	// Readout scaler: split product, round and saturate
	always_comb begin
		abs_v = sh_link[0][ACC_W-1] ? ACC_W'(-sh_link[0]) : ACC_W'(sh_link[0]);
		total = (TOT_W'(ph_s1) << HALF_W) + TOT_W'(pl_s1) +
			TOT_W'(1 << (shtm_pkg::WEIGHT_FRAC - 1));
		qv    = total[TOT_W-1:shtm_pkg::WEIGHT_FRAC];
		if (neg_s1) begin
			entry_n = (qv > Q_W'(32'h8000_0000)) ? 32'sh8000_0000 :
				shtm_pkg::ENTRY_W'(-qv);
		end else begin
			entry_n = (qv > Q_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF :
				shtm_pkg::ENTRY_W'(qv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1         <= issue;
			result_valid_q <= vld_s1;
		end
	end

	// Scaler payload: advance only when the result register can move
	always_ff @(posedge clk) begin
		if (en) begin
			if (issue) begin
				neg_s1  <= sh_link[0][ACC_W-1];
				ph_s1   <= PP_W'(abs_v[ACC_W-1:HALF_W]) * PP_W'(weight_q);
				pl_s1   <= PP_W'(abs_v[HALF_W-1:0]) * PP_W'(weight_q);
				col_s1  <= col_q;
				row_s1  <= row_q;
				last_s1 <= {1'b0, col_q} == run_n2_q - N2_W'(1);
			end
			if (vld_s1) begin
				result_q.entry_value  <= entry_n;
				result_q.entry_row    <= row_s1;
				result_q.entry_column <= col_s1;
				result_q.last_of_row  <= last_s1;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
